// ----- rtl/core/bkr_pkg.sv -----
package bkr_pkg;

  localparam int unsigned NUM_SLOTS   = 6;
  localparam int unsigned NUM_MODS    = 8;
  localparam int unsigned NUM_EVENTS  = NUM_MODS + 2 * NUM_SLOTS;
  localparam int unsigned USAGE_FIRST = 8'h04;
  localparam int unsigned USAGE_LAST  = 8'h66;
  localparam int unsigned USAGE_COUNT = USAGE_LAST - USAGE_FIRST + 1;

  typedef logic [7:0] usage_t;
  typedef logic [6:0] key_code_t;

  // What one lane found for its slot
  typedef struct packed {
    logic      hit;
    key_code_t code;
  } lane_res_t;

  localparam key_code_t USAGE_ROM [0:USAGE_COUNT-1] = '{
    7'd30, 7'd48, 7'd46, 7'd32, 7'd18, 7'd33, 7'd34, 7'd35,
    7'd23, 7'd36, 7'd37, 7'd38, 7'd50, 7'd49, 7'd24, 7'd25,
    7'd16, 7'd19, 7'd31, 7'd20, 7'd22, 7'd47, 7'd17, 7'd45,
    7'd21, 7'd44, 7'd2,  7'd3,  7'd4,  7'd5,  7'd6,  7'd7,
    7'd8,  7'd9,  7'd10, 7'd11, 7'd28, 7'd1,  7'd14, 7'd15,
    7'd57, 7'd12, 7'd13, 7'd26, 7'd27, 7'd43, 7'd0,  7'd39,
    7'd40, 7'd41, 7'd51, 7'd52, 7'd53, 7'd58, 7'd59, 7'd60,
    7'd61, 7'd62, 7'd63, 7'd64, 7'd65, 7'd66, 7'd67, 7'd68,
    7'd87, 7'd88, 7'd99, 7'd70, 7'd119, 7'd110, 7'd102, 7'd104,
    7'd111, 7'd107, 7'd109, 7'd106, 7'd105, 7'd108, 7'd103, 7'd69,
    7'd98, 7'd55, 7'd74, 7'd78, 7'd96, 7'd79, 7'd80, 7'd81,
    7'd75, 7'd76, 7'd77, 7'd71, 7'd72, 7'd73, 7'd82, 7'd83,
    7'd0,  7'd127, 7'd116
  };

  localparam key_code_t MOD_ROM [0:NUM_MODS-1] = '{
    7'd29, 7'd42, 7'd56, 7'd125, 7'd97, 7'd54, 7'd100, 7'd126
  };

  // Translate a usage to a key code; zero means no event
  function automatic key_code_t usage_to_key(input usage_t usage);
    logic [6:0] idx;
    key_code_t  code;
    idx  = 7'(usage - 8'(USAGE_FIRST));
    code = '0;
    if (usage >= 8'(USAGE_FIRST) && usage <= 8'(USAGE_LAST)) begin
      code = USAGE_ROM[idx];
    end
    return code;
  endfunction

endpackage

// ----- rtl/core/boot_keyboard_report_to_key_events.sv -----
// Boot keyboard report to key events.
// Input channel: one transaction carries a boot-protocol report (modifier
// byte, six key usages, received byte count). Bytes at or past the count
// keep the previous report's values. Output channel: one transaction per
// key event (key code, pressed, last_event on the final event of a report).
// Events come in order: changed modifier bits 0..7, presses for new usages
// in slot order, releases for vanished usages in slot order.
// Twelve slot lanes and the modifier compare evaluate a report in the cycle
// it is accepted; the event queue then emits one event per cycle while the
// output is not stalled. Events pass from the pending mask to the output register.
// A report yields at most 20 events, and the queue holds it until its last
// event is taken. The next report is
// accepted in the cycle the previous report's last event enters the output
// register, so reports follow back to back.
// Reset: modifier history is 0xFF, held modifier byte and key slots are 0,
// so the first report releases every clear modifier bit.
// A stalled output holds its event; the queue and the input then wait.
module boot_keyboard_report_to_key_events (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_modifier_byte,
  input  logic [7:0] in_key_slot_0,
  input  logic [7:0] in_key_slot_1,
  input  logic [7:0] in_key_slot_2,
  input  logic [7:0] in_key_slot_3,
  input  logic [7:0] in_key_slot_4,
  input  logic [7:0] in_key_slot_5,
  input  logic [3:0] in_report_length,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_key_code,
  output logic       out_pressed,
  output logic       out_last_event
);

  localparam int unsigned NS = bkr_pkg::NUM_SLOTS;
  localparam int unsigned NM = bkr_pkg::NUM_MODS;
  localparam int unsigned NE = bkr_pkg::NUM_EVENTS;

  logic [7:0]          held_mod_r, held_mod_nxt;
  logic [7:0]          prev_mod_r, prev_mod_nxt;
  bkr_pkg::usage_t     prev_slot_r [NS];
  bkr_pkg::usage_t     cur [NS];
  bkr_pkg::usage_t     in_slot [NS];
  logic [7:0]          mod;
  logic                accept, busy;
  bkr_pkg::lane_res_t  press_res [NS];
  bkr_pkg::lane_res_t  rel_res [NS];
  logic [NE-1:0]       ev_mask, ev_down;
  bkr_pkg::key_code_t  ev_code [NE];

  assign in_slot[0] = in_key_slot_0;
  assign in_slot[1] = in_key_slot_1;
  assign in_slot[2] = in_key_slot_2;
  assign in_slot[3] = in_key_slot_3;
  assign in_slot[4] = in_key_slot_4;
  assign in_slot[5] = in_key_slot_5;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  // Fill missing bytes from the held report (counts above 8 act as 8)
  assign mod = (in_report_length != 4'd0) ? in_modifier_byte : held_mod_r;
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      cur[i] = (in_report_length > 4'(i + 2)) ? in_slot[i] : prev_slot_r[i];
    end
  end

  // Press and release lanes, one per slot
  for (genvar g = 0; g < NS; g++) begin : g_lane
    bkr_slot_lane u_press (
      .usage (cur[g]),
      .other (prev_slot_r),
      .res   (press_res[g])
    );
    bkr_slot_lane u_rel (
      .usage (prev_slot_r[g]),
      .other (cur),
      .res   (rel_res[g])
    );
  end

  // Merge modifier changes and lane hits into one ordered event vector
  always_comb begin
    for (int i = 0; i < NM; i++) begin
      ev_mask[i] = mod[i] ^ prev_mod_r[i];
      ev_code[i] = bkr_pkg::MOD_ROM[i];
      ev_down[i] = mod[i];
    end
    for (int i = 0; i < NS; i++) begin
      ev_mask[NM + i]      = press_res[i].hit;
      ev_code[NM + i]      = press_res[i].code;
      ev_down[NM + i]      = 1'b1;
      ev_mask[NM + NS + i] = rel_res[i].hit;
      ev_code[NM + NS + i] = rel_res[i].code;
      ev_down[NM + NS + i] = 1'b0;
    end
  end

  bkr_event_queue u_queue (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (accept),
    .load_mask      (ev_mask),
    .load_code      (ev_code),
    .load_down      (ev_down),
    .busy           (busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_key_code   (out_key_code),
    .out_pressed    (out_pressed),
    .out_last_event (out_last_event)
  );

  assign held_mod_nxt = accept ? mod : held_mod_r;
  assign prev_mod_nxt = accept ? mod : prev_mod_r;

  // Advance report history on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_mod_r <= 8'h00;
      prev_mod_r <= 8'hFF;
      for (int i = 0; i < NS; i++) begin
        prev_slot_r[i] <= '0;
      end
    end else begin
      held_mod_r <= held_mod_nxt;
      prev_mod_r <= prev_mod_nxt;
      if (accept) begin
        prev_slot_r <= cur;
      end
    end
  end

endmodule

// ----- rtl/core/bkr_slot_lane.sv -----
module bkr_slot_lane (
  input  bkr_pkg::usage_t   usage,
  input  bkr_pkg::usage_t   other [bkr_pkg::NUM_SLOTS],
  output bkr_pkg::lane_res_t res
);

  logic              found;
  bkr_pkg::key_code_t code;

  // Look for the usage among the other report's slots
  always_comb begin
    found = 1'b0;
    for (int m = 0; m < bkr_pkg::NUM_SLOTS; m++) begin
      if (other[m] == usage) begin
        found = 1'b1;
      end
    end
  end

  assign code     = bkr_pkg::usage_to_key(usage);
  assign res.code = code;
  assign res.hit  = (usage != '0) && !found && (code != '0);

endmodule

// ----- rtl/core/bkr_event_queue.sv -----
module bkr_event_queue (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  load,
  input  logic [bkr_pkg::NUM_EVENTS-1:0]        load_mask,
  input  bkr_pkg::key_code_t                    load_code [bkr_pkg::NUM_EVENTS],
  input  logic [bkr_pkg::NUM_EVENTS-1:0]        load_down,
  output logic                                  busy,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output bkr_pkg::key_code_t                    out_key_code,
  output logic                                  out_pressed,
  output logic                                  out_last_event
);

  localparam int unsigned N = bkr_pkg::NUM_EVENTS;

  logic [N-1:0]       mask_r, mask_nxt, mask_left, pick;
  bkr_pkg::key_code_t code_r [N];
  logic [N-1:0]       down_r;
  logic               out_valid_r, out_valid_nxt;
  bkr_pkg::key_code_t key_r, key_nxt;
  logic               prs_r, prs_nxt, last_r, last_nxt;
  logic               take;

  // Lowest pending event goes out first
  assign take = (|mask_r) && (!out_valid_r || !out_stall);
  assign pick = mask_r & (~mask_r + N'(1));

  always_comb begin
    key_nxt = '0;
    prs_nxt = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (pick[i]) begin
        key_nxt = key_nxt | code_r[i];
        prs_nxt = prs_nxt | down_r[i];
      end
    end
  end

  assign mask_left = take ? (mask_r & ~pick) : mask_r;
  assign last_nxt  = ((mask_r & ~pick) == '0);
  assign busy      = |mask_left;
  assign mask_nxt  = load ? load_mask : mask_left;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold pending mask and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture event payloads and the outgoing transaction
  always_ff @(posedge clk) begin
    if (load) begin
      code_r <= load_code;
      down_r <= load_down;
    end
    if (take) begin
      key_r  <= key_nxt;
      prs_r  <= prs_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key_code   = key_r;
  assign out_pressed    = prs_r;
  assign out_last_event = last_r;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_REPORTS  = 238;
  localparam int QUIET_TAIL      = 30;
  localparam int HOLD_OFF_AT     = 120;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 25;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PRINT_LIMIT     = 30;

  typedef struct packed {
    logic [7:0]      modifiers;
    logic [5:0][7:0] slots;
    logic [3:0]      length;
  } report_t;

  typedef struct packed {
    bkr_pkg::key_code_t code;
    logic               pressed;
    logic               last_event;
  } key_event_t;

  // HID usage 0x04..0x66 to key code; zero marks a hole in the map
  localparam bkr_pkg::key_code_t USAGE_KEYMAP [0:98] = '{
    7'd30, 7'd48, 7'd46, 7'd32, 7'd18, 7'd33, 7'd34, 7'd35,
    7'd23, 7'd36, 7'd37, 7'd38, 7'd50, 7'd49, 7'd24, 7'd25,
    7'd16, 7'd19, 7'd31, 7'd20, 7'd22, 7'd47, 7'd17, 7'd45,
    7'd21, 7'd44, 7'd2,  7'd3,  7'd4,  7'd5,  7'd6,  7'd7,
    7'd8,  7'd9,  7'd10, 7'd11, 7'd28, 7'd1,  7'd14, 7'd15,
    7'd57, 7'd12, 7'd13, 7'd26, 7'd27, 7'd43, 7'd0,  7'd39,
    7'd40, 7'd41, 7'd51, 7'd52, 7'd53, 7'd58, 7'd59, 7'd60,
    7'd61, 7'd62, 7'd63, 7'd64, 7'd65, 7'd66, 7'd67, 7'd68,
    7'd87, 7'd88, 7'd99, 7'd70, 7'd119, 7'd110, 7'd102, 7'd104,
    7'd111, 7'd107, 7'd109, 7'd106, 7'd105, 7'd108, 7'd103, 7'd69,
    7'd98, 7'd55, 7'd74, 7'd78, 7'd96, 7'd79, 7'd80, 7'd81,
    7'd75, 7'd76, 7'd77, 7'd71, 7'd72, 7'd73, 7'd82, 7'd83,
    7'd0,  7'd127, 7'd116
  };

  // Key codes of modifier bits 0..7
  localparam bkr_pkg::key_code_t MODIFIER_KEYMAP [0:7] = '{
    7'd29, 7'd42, 7'd56, 7'd125, 7'd97, 7'd54, 7'd100, 7'd126
  };

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic               out_stall    = 1'b0;
  report_t            shown_report = '0;
  logic               in_stall;
  logic               out_valid;
  bkr_pkg::key_code_t out_key_code;
  logic               out_pressed;
  logic               out_last_event;

  // Stimulus and expected key events
  report_t    report_q[$];
  key_event_t key_event_q[$];

  // Decoder state as the block should hold it
  logic [7:0]      decoded_mods = 8'hFF;
  logic [7:0]      held_mods    = 8'h00;
  logic [5:0][7:0] held_slots   = '0;

  int total_reports = 0;
  int reports_taken = 0;
  int events_seen   = 0;
  int presses_seen  = 0;
  int short_reports = 0;
  int long_reports  = 0;
  int mismatches    = 0;
  int send_gap      = 0;
  int stall_left    = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;

  boot_keyboard_report_to_key_events dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_modifier_byte (shown_report.modifiers),
    .in_key_slot_0    (shown_report.slots[0]),
    .in_key_slot_1    (shown_report.slots[1]),
    .in_key_slot_2    (shown_report.slots[2]),
    .in_key_slot_3    (shown_report.slots[3]),
    .in_key_slot_4    (shown_report.slots[4]),
    .in_key_slot_5    (shown_report.slots[5]),
    .in_report_length (shown_report.length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_key_code     (out_key_code),
    .out_pressed      (out_pressed),
    .out_last_event   (out_last_event)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bkr_pkg::key_code_t usage_key(input logic [7:0] usage);
    if (usage < 8'h04 || usage > 8'h66) return '0;
    return USAGE_KEYMAP[7'(usage - 8'h04)];
  endfunction

  function automatic bit slots_hold(input logic [5:0][7:0] slots, input logic [7:0] usage);
    for (int i = 0; i < 6; i++) begin
      if (slots[i] == usage) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Turn one report into its key events and advance the held state
  task automatic decode_report(input report_t r);
    int unsigned        len;
    logic [7:0]         mods;
    logic [5:0][7:0]    now_slots;
    key_event_t         batch[$];
    bkr_pkg::key_code_t code;
    len  = (r.length > 4'd8) ? 8 : r.length;
    mods = (len > 0) ? r.modifiers : held_mods;
    for (int i = 0; i < 6; i++) begin
      now_slots[i] = (len > i + 2) ? r.slots[i] : held_slots[i];
    end
    for (int i = 0; i < 8; i++) begin
      if (mods[i] != decoded_mods[i]) batch.push_back('{MODIFIER_KEYMAP[i], mods[i], 1'b0});
    end
    // presses for usages that are new in this report
    for (int i = 0; i < 6; i++) begin
      code = usage_key(now_slots[i]);
      if (now_slots[i] != '0 && !slots_hold(held_slots, now_slots[i]) && code != '0) begin
        batch.push_back('{code, 1'b1, 1'b0});
      end
    end
    // releases for usages that vanished
    for (int i = 0; i < 6; i++) begin
      code = usage_key(held_slots[i]);
      if (held_slots[i] != '0 && !slots_hold(now_slots, held_slots[i]) && code != '0) begin
        batch.push_back('{code, 1'b0, 1'b0});
      end
    end
    if (batch.size() > 0) batch[batch.size() - 1].last_event = 1'b1;
    foreach (batch[k]) key_event_q.push_back(batch[k]);
    held_mods    = mods;
    decoded_mods = mods;
    held_slots   = now_slots;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      if (mismatches < PRINT_LIMIT) $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic add_report(input logic [7:0] mods, input logic [3:0] len,
                            input logic [7:0] s0, s1, s2, s3, s4, s5);
    report_t r;
    r.modifiers = mods;
    r.length    = len;
    r.slots     = {s5, s4, s3, s2, s1, s0};
    report_q.push_back(r);
  endtask

  // Edge cases: reset modifiers, map ends and holes, short and long reports
  task automatic queue_directed_reports();
    add_report(8'h00, 4'd8,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    add_report(8'hFF, 4'd8,  8'h04, 8'h66, 8'h65, 8'h32, 8'h64, 8'h03);
    add_report(8'hFF, 4'd8,  8'h04, 8'h66, 8'h65, 8'h32, 8'h64, 8'h03);
    add_report(8'hFF, 4'd8,  8'h67, 8'hFF, 8'h00, 8'h80, 8'h05, 8'h05);
    add_report(8'h55, 4'd8,  8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    add_report(8'h00, 4'd0,  8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66);
    add_report(8'hAA, 4'd1,  8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66);
    add_report(8'h0F, 4'd2,  8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66);
    add_report(8'h0F, 4'd3,  8'h1E, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66);
    add_report(8'hF0, 4'd4,  8'h1F, 8'h20, 8'h33, 8'h44, 8'h55, 8'h66);
    add_report(8'hF0, 4'd5,  8'h21, 8'h22, 8'h23, 8'h44, 8'h55, 8'h66);
    add_report(8'h3C, 4'd6,  8'h21, 8'h22, 8'h23, 8'h24, 8'h55, 8'h66);
    add_report(8'h3C, 4'd7,  8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h66);
    add_report(8'hC3, 4'd9,  8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
    add_report(8'h5A, 4'd15, 8'h1E, 8'h1E, 8'h1E, 8'h1E, 8'h1E, 8'h1E);
    add_report(8'h5A, 4'd15, 8'h1E, 8'h1E, 8'h1E, 8'h1E, 8'h1E, 8'h1E);
    add_report(8'h00, 4'd8,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    add_report(8'hFF, 4'd8,  8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D);
    add_report(8'hFF, 4'd12, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    add_report(8'h80, 4'd8,  8'h63, 8'h62, 8'h61, 8'h60, 8'h5F, 8'h5E);
    add_report(8'h01, 4'd10, 8'h39, 8'h53, 8'h47, 8'hE0, 8'hE7, 8'h01);
    add_report(8'h00, 4'd8,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  // Mostly full reports that evolve like typing, plus short, long and noise reports
  task automatic queue_random_reports();
    report_t         r;
    logic [5:0][7:0] recent;
    logic [7:0]      recent_mods;
    int unsigned     kind;
    int unsigned     roll;
    recent      = '0;
    recent_mods = '0;
    for (int n = 0; n < RANDOM_REPORTS; n++) begin
      kind = $urandom_range(0, 9);
      roll = $urandom_range(0, 2);
      if (roll == 0) r.modifiers = recent_mods;
      else if (roll == 1) r.modifiers = recent_mods ^ (8'h01 << $urandom_range(0, 7));
      else r.modifiers = 8'($urandom);
      for (int i = 0; i < 6; i++) begin
        roll = $urandom_range(0, 19);
        if (kind == 9 || roll == 19) r.slots[i] = 8'($urandom);
        else if (roll < 8) r.slots[i] = recent[i];
        else if (roll < 13) r.slots[i] = 8'h00;
        else r.slots[i] = 8'($urandom_range(8'h04, 8'h66));
      end
      if (kind < 7) r.length = 4'd8;
      else if (kind < 9) r.length = 4'($urandom_range(0, 7));
      else r.length = 4'($urandom_range(9, 15));
      report_q.push_back(r);
      recent      = r.slots;
      recent_mods = r.modifiers;
    end
  endtask

  // Driver: present reports, hold a stalled one, insert gaps between them
  always @(posedge clk) begin
    report_t next_report;
    logic    next_valid;
    bit      calm;
    next_report = shown_report;
    next_valid  = in_valid;
    calm = ((report_q.size() / 40) % 3 == 1) || report_q.size() <= QUIET_TAIL;
    if (rst_n && (!in_valid || !in_stall)) begin
      next_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (report_q.size() > 0) begin
        if (in_valid && !calm && $urandom_range(0, 3) == 0) begin
          send_gap = $urandom_range(0, 7);
        end else begin
          next_report = report_q.pop_front();
          next_valid  = 1'b1;
        end
      end
    end
    in_valid     <= next_valid;
    shown_report <= next_report;
  end

  // Monitor: check each key event, then predict the report taken this cycle
  always @(posedge clk) begin
    key_event_t want;
    logic       next_stall;
    bit         quiet;
    next_stall = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (key_event_q.size() == 0) begin
          if (mismatches < PRINT_LIMIT) begin
            $error("unexpected key event: code %0d pressed %0d last_event %0d",
                   out_key_code, out_pressed, out_last_event);
          end
          mismatches++;
        end else begin
          want = key_event_q.pop_front();
          check_field("key_code", int'(want.code), int'(out_key_code));
          check_field("pressed", int'(want.pressed), int'(out_pressed));
          check_field("last_event", int'(want.last_event), int'(out_last_event));
          events_seen++;
          if (want.pressed) presses_seen++;
        end
      end
      if (in_valid && !in_stall) begin
        decode_report(shown_report);
        reports_taken++;
        if (shown_report.length < 4'd8) short_reports++;
        if (shown_report.length > 4'd8) long_reports++;
      end
      // Hold off once for a long stretch so the block backs up
      if (!hold_done && reports_taken >= HOLD_OFF_AT) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_done = 1'b1;
      end
      quiet = ((reports_taken / 40) % 3 == 2) || reports_taken + QUIET_TAIL >= total_reports;
      if (hold_left > 0) begin
        hold_left--;
        next_stall = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        next_stall = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        next_stall = 1'b1;
      end
    end
    out_stall <= next_stall;
  end

  // Watchdog: end the run when neither channel moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout after %0d idle cycles", WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    queue_directed_reports();
    queue_random_reports();
    total_reports = report_q.size();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (reports_taken < total_reports || key_event_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d reports (%0d short, %0d over-length), %0d key events checked",
             reports_taken, short_reports, long_reports, events_seen);
    $display("%0d presses, %0d releases, %0d mismatches",
             presses_seen, events_seen - presses_seen, mismatches);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
